// ===== hw/rtl/svf_pkg.sv =====
// Shared types, constants and the microcode table of the stereo state-variable filter.
// Used by svf_useq, svf_dp and state_variable_filter_stereo; depends on nothing else.
package svf_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 18;
  localparam int VOL_BITS    = 8;
  localparam int MODE_BITS   = 2;
  localparam int CFG_IDX_BITS = 2;

  // The multiplier's second operand is split at this bit into two partial products.
  localparam int SPLIT_BITS = 24;
  // Volume is in 1/256 steps.
  localparam int VOL_SHIFT  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_FREQ    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DAMPING = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_VOLUME  = 2'd3;

  // Output mode codes.
  localparam logic [MODE_BITS-1:0] MODE_LP    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HP    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BP    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_NOTCH = 2'd3;

  // Reset value of the volume configuration register.
  localparam logic [VOL_BITS-1:0] VOLUME_RESET = 8'd255;

  // Saturation limits of the output sample.
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

  // Payload of one input transfer.
  typedef struct packed {
    logic                          channel;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } svf_in_t;

  // Payload of one output transfer.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          out_channel;
  } svf_out_t;

  // Microcode fields.
  typedef enum logic [1:0] {A_FREQ, A_DAMP, A_VOL} a_sel_t;
  typedef enum logic [1:0] {B_BP, B_HP, B_SUM} b_sel_t;
  typedef enum logic {PART_LO, PART_HI} part_t;
  typedef enum logic [1:0] {WB_NONE, WB_LP, WB_HP, WB_BP} wb_t;
  typedef enum logic [1:0] {SEQ_NEXT, SEQ_LOOP, SEQ_DONE} seq_t;

  typedef struct packed {
    logic   mul_en;
    a_sel_t a_sel;
    b_sel_t b_sel;
    part_t  part;
    wb_t    wb;
    logic   half_en;
    logic   sum_en;
    seq_t   seq;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ucode_t uc;
    logic   load;
    logic   finish;
  } seq_ctrl_t;

  localparam int NUM_STEPS = 13;
  localparam int STEP_BITS = $clog2(NUM_STEPS);
  localparam logic [STEP_BITS-1:0] STEP_LOOP_TOP = '0;

  localparam ucode_t UCODE_NOP = '{1'b0, A_FREQ, B_BP, PART_LO, WB_NONE, 1'b0, 1'b0, SEQ_NEXT};

  // The program. Field order: mul_en, a_sel, b_sel, part, wb, half_en, sum_en, seq.
  // Steps 0 to 9 form one filter pass; steps 10 to 12 apply volume and deliver.
  localparam ucode_t UCODE [NUM_STEPS] = '{
    '{1'b1, A_FREQ, B_BP,  PART_LO, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // f*bp, low part
    '{1'b1, A_FREQ, B_BP,  PART_HI, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // f*bp, high part
    '{1'b1, A_DAMP, B_BP,  PART_LO, WB_LP,   1'b0, 1'b0, SEQ_NEXT},  // lp update, q*bp low
    '{1'b1, A_DAMP, B_BP,  PART_HI, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // q*bp, high part
    '{1'b0, A_FREQ, B_BP,  PART_LO, WB_HP,   1'b0, 1'b0, SEQ_NEXT},  // hp update
    '{1'b1, A_FREQ, B_HP,  PART_LO, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // f*hp, low part
    '{1'b1, A_FREQ, B_HP,  PART_HI, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // f*hp, high part
    '{1'b0, A_FREQ, B_BP,  PART_LO, WB_BP,   1'b0, 1'b0, SEQ_NEXT},  // bp update
    '{1'b0, A_FREQ, B_BP,  PART_LO, WB_NONE, 1'b1, 1'b0, SEQ_NEXT},  // halve selected output
    '{1'b0, A_FREQ, B_BP,  PART_LO, WB_NONE, 1'b0, 1'b1, SEQ_LOOP},  // accumulate, next pass
    '{1'b1, A_VOL,  B_SUM, PART_LO, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // sum*volume, low part
    '{1'b1, A_VOL,  B_SUM, PART_HI, WB_NONE, 1'b0, 1'b0, SEQ_NEXT},  // sum*volume, high part
    '{1'b0, A_FREQ, B_BP,  PART_LO, WB_NONE, 1'b0, 1'b0, SEQ_DONE}   // saturate and deliver
  };

endpackage

// ===== hw/rtl/svf_useq.sv =====
// Microcode sequencer of the stereo state-variable filter: step counter, pass counter,
// program table lookup and the jump logic. Depends on svf_pkg.
module svf_useq #(
  parameter int OVERSAMPLE = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                hold,
  output logic                busy,
  output svf_pkg::seq_ctrl_t  ctl
);

  localparam int PASS_BITS = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
  localparam logic [PASS_BITS-1:0] PASS_LAST = PASS_BITS'(OVERSAMPLE - 1);

  typedef enum logic {IDLE, RUN} state_t;

  state_t                          state;
  logic [svf_pkg::STEP_BITS-1:0]   step;
  logic [PASS_BITS-1:0]            pass;
  svf_pkg::ucode_t                 uc;

  // Current control word; idle cycles issue no operation.
  always_comb begin
    if (state == RUN) begin
      uc = svf_pkg::UCODE[step];
    end else begin
      uc = svf_pkg::UCODE_NOP;
    end
  end

  assign busy       = (state == RUN);
  assign ctl.uc     = uc;
  assign ctl.load   = start;
  assign ctl.finish = (state == RUN) && (uc.seq == svf_pkg::SEQ_DONE) && !hold;

  // Step counter with the loop jump and the final wait for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
      pass  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= RUN;
            step  <= '0;
            pass  <= '0;
          end
        end
        RUN: begin
          case (uc.seq)
            svf_pkg::SEQ_NEXT: begin
              step <= step + 1'b1;
            end
            svf_pkg::SEQ_LOOP: begin
              if (pass == PASS_LAST) begin
                step <= step + 1'b1;
              end else begin
                step <= svf_pkg::STEP_LOOP_TOP;
                pass <= pass + 1'b1;
              end
            end
            svf_pkg::SEQ_DONE: begin
              if (!hold) begin
                state <= IDLE;
              end
            end
            default: begin
              state <= IDLE;
            end
          endcase
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/svf_dp.sv =====
// Datapath of the stereo state-variable filter: per-channel state, working registers,
// one shared multiplier with a partial-product adder, and output saturation.
// Depends on svf_pkg; driven by the control word from svf_useq.
module svf_dp #(
  parameter int FRAC_BITS  = 16,
  parameter int STATE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  svf_pkg::seq_ctrl_t                  ctl,
  input  logic [svf_pkg::COEF_BITS-1:0]       freq_coef,
  input  logic [svf_pkg::COEF_BITS-1:0]       damping_coef,
  input  logic [svf_pkg::MODE_BITS-1:0]       mode,
  input  logic [svf_pkg::VOL_BITS-1:0]        volume,
  input  svf_pkg::svf_in_t                    src_item,
  output svf_pkg::svf_out_t                   result
);

  localparam int SB = STATE_BITS;
  localparam int CB = svf_pkg::COEF_BITS;
  localparam int SP = svf_pkg::SPLIT_BITS;
  // Second multiplier operand: state values and the output sum.
  localparam int BW = SB + 2;
  localparam int HW = BW - SP;
  // Signed width that holds either partial operand.
  localparam int PW = (HW + 1 > SP + 1) ? HW + 1 : SP + 1;
  localparam int MW = CB + 1 + PW;
  localparam int FW = MW + SP + 1 + FRAC_BITS;
  localparam int QW = FW - svf_pkg::VOL_SHIFT;

  logic signed [svf_pkg::SAMPLE_BITS-1:0] x;
  logic                                   ch;
  logic signed [SB-1:0]                   lp;
  logic signed [SB-1:0]                   bp;
  logic signed [SB-1:0]                   hp;
  logic signed [SB-1:0]                   half;
  logic signed [BW-1:0]                   sum;
  logic signed [MW-1:0]                   p;
  logic signed [MW-1:0]                   plo;
  logic signed [SB-1:0]                   lp_st [2];
  logic signed [SB-1:0]                   bp_st [2];

  logic [CB-1:0]          a_op;
  logic signed [BW-1:0]   b_op;
  logic signed [PW-1:0]   b_part;
  logic signed [MW-1:0]   mul;
  logic signed [FW-1:0]   full;
  logic signed [SB-1:0]   fm;
  logic signed [SB-1:0]   x_ext;
  logic signed [SB-1:0]   notch;
  logic signed [SB-1:0]   sel;
  logic signed [SB-1:0]   sel_adj;
  logic signed [QW-1:0]   scaled;
  logic                   in_range;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (ctl.uc.a_sel)
      svf_pkg::A_FREQ: a_op = freq_coef;
      svf_pkg::A_DAMP: a_op = damping_coef;
      svf_pkg::A_VOL:  a_op = {{(CB - svf_pkg::VOL_BITS){1'b0}}, volume};
      default:         a_op = '0;
    endcase
    case (ctl.uc.b_sel)
      svf_pkg::B_BP:  b_op = {{2{bp[SB-1]}}, bp};
      svf_pkg::B_HP:  b_op = {{2{hp[SB-1]}}, hp};
      svf_pkg::B_SUM: b_op = sum;
      default:        b_op = '0;
    endcase
    if (ctl.uc.part == svf_pkg::PART_LO) begin
      b_part = {{(PW - SP){1'b0}}, b_op[SP-1:0]};
    end else begin
      b_part = {{(PW - HW){b_op[BW-1]}}, b_op[BW-1:SP]};
    end
  end

  assign mul = $signed({1'b0, a_op}) * b_part;

  // Exact product from the two registered partial products.
  assign full = $signed({{(FW - MW){plo[MW-1]}}, plo})
              + $signed({{(FW - MW){p[MW-1]}}, p} << SP);
  assign fm   = full[FRAC_BITS +: SB];

  // Mode selection and halving with truncation toward zero.
  assign x_ext = {{(SB - svf_pkg::SAMPLE_BITS){x[svf_pkg::SAMPLE_BITS-1]}}, x};
  assign notch = hp + lp;
  always_comb begin
    case (mode)
      svf_pkg::MODE_LP:    sel = lp;
      svf_pkg::MODE_HP:    sel = hp;
      svf_pkg::MODE_BP:    sel = bp;
      svf_pkg::MODE_NOTCH: sel = notch;
      default:             sel = notch;
    endcase
  end
  assign sel_adj = sel + {{(SB - 1){1'b0}}, sel[SB-1]};

  // Volume scaling is a floor shift; saturate when the upper bits are not all sign.
  assign scaled   = full[FW-1:svf_pkg::VOL_SHIFT];
  assign in_range = (&scaled[QW-1:svf_pkg::SAMPLE_BITS-1])
                  | ~(|scaled[QW-1:svf_pkg::SAMPLE_BITS-1]);
  always_comb begin
    if (in_range) begin
      result.sample_out = scaled[svf_pkg::SAMPLE_BITS-1:0];
    end else if (scaled[QW-1]) begin
      result.sample_out = svf_pkg::SAMPLE_MIN;
    end else begin
      result.sample_out = svf_pkg::SAMPLE_MAX;
    end
  end
  assign result.out_channel = ch;

  // Per-channel filter state, written back when a result is delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      lp_st[0] <= '0;
      lp_st[1] <= '0;
      bp_st[0] <= '0;
      bp_st[1] <= '0;
    end else if (ctl.finish) begin
      lp_st[ch] <= lp;
      bp_st[ch] <= bp;
    end
  end

  // Working registers, stepped by the control word.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x   <= src_item.sample_in;
      ch  <= src_item.channel;
      lp  <= lp_st[src_item.channel];
      bp  <= bp_st[src_item.channel];
      sum <= '0;
    end else begin
      case (ctl.uc.wb)
        svf_pkg::WB_LP: lp <= lp + fm;
        svf_pkg::WB_HP: hp <= x_ext - lp - fm;
        svf_pkg::WB_BP: bp <= bp + fm;
        default: ;
      endcase
      if (ctl.uc.half_en) begin
        half <= sel_adj >>> 1;
      end
      if (ctl.uc.sum_en) begin
        sum <= sum + {{2{half[SB-1]}}, half};
      end
    end
    if (ctl.uc.mul_en) begin
      p <= mul;
      if (ctl.uc.part == svf_pkg::PART_HI) begin
        plo <= p;
      end
    end
  end

endmodule

// ===== hw/rtl/state_variable_filter_stereo.sv =====
// Top level of the two-channel state-variable filter: configuration registers,
// output register and the sequencer and datapath. Depends on svf_pkg, svf_useq, svf_dp.
//
// Each accepted sample runs OVERSAMPLE passes of the Chamberlin filter on the state
// of its channel, then scales the summed mode output by volume and saturates it.
// One item occupies the block from the transfer in until its result is delivered,
// and no new item is taken in that time. The run length is set by the single shared
// multiplier: each of the three products of a pass takes two partial-product steps
// and a write-back step, and the volume product takes three more. The result is held
// in an output register, so a new item is taken while an older result waits; the
// block waits at its last step only while the output register is full and stalled.
module state_variable_filter_stereo #(
  parameter int FRAC_BITS  = 16,
  parameter int STATE_BITS = 32,
  parameter int OVERSAMPLE = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 src_valid,
  output logic                                 src_stall,
  input  svf_pkg::svf_in_t                     src_data,
  output logic                                 dst_valid,
  input  logic                                 dst_stall,
  output svf_pkg::svf_out_t                    dst_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [svf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [svf_pkg::COEF_BITS-1:0]        cfg_data
);

  logic [svf_pkg::COEF_BITS-1:0] freq_coef;
  logic [svf_pkg::COEF_BITS-1:0] damping_coef;
  logic [svf_pkg::MODE_BITS-1:0] mode;
  logic [svf_pkg::VOL_BITS-1:0]  volume;
  logic                          busy;
  logic                          start;
  logic                          hold;
  svf_pkg::seq_ctrl_t            ctl;
  svf_pkg::svf_out_t             result;

  assign cfg_ready = 1'b1;
  assign src_stall = busy;
  assign start     = src_valid && !src_stall;
  assign hold      = dst_valid && dst_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_coef    <= '0;
      damping_coef <= '0;
      mode         <= svf_pkg::MODE_LP;
      volume       <= svf_pkg::VOLUME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        svf_pkg::REG_FREQ:    freq_coef    <= cfg_data;
        svf_pkg::REG_DAMPING: damping_coef <= cfg_data;
        svf_pkg::REG_MODE:    mode         <= cfg_data[svf_pkg::MODE_BITS-1:0];
        svf_pkg::REG_VOLUME:  volume       <= cfg_data[svf_pkg::VOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  svf_useq #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .hold  (hold),
    .busy  (busy),
    .ctl   (ctl)
  );

  svf_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .STATE_BITS (STATE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .freq_coef    (freq_coef),
    .damping_coef (damping_coef),
    .mode         (mode),
    .volume       (volume),
    .src_item     (src_data),
    .result       (result)
  );

  // Output register: loaded when the sequencer delivers, emptied by a transfer out.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (ctl.finish) begin
      dst_valid <= 1'b1;
    end else if (dst_valid && !dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      dst_data <= result;
    end
  end

  // A result is never delivered into a full, stalled output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |-> !(dst_valid && dst_stall))
    else $error("result delivered while output register was held");

  // After an input transfer the sequencer is busy and takes no further item.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start |=> src_stall)
    else $error("sequencer not busy after input transfer");

  // Delivery ends the item: the block is ready again in the next cycle.
  a_idle_after_finish: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> !src_stall && dst_valid)
    else $error("sequencer did not return to idle after delivery");

endmodule
